// ----- rtl/core/mro_pkg.sv -----
`default_nettype none
package mro_pkg;

  // fixed field widths
  localparam int ROW_LEN_W = 7;
  localparam int AREA_W    = 13;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 7'd64;
  localparam logic [AREA_W-1:0]    AREA_MAX      = 13'h1FFF;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start;
    logic walk;
    logic finish;
  } mro_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic skip;
    logic walk_more;
    logic last;
    logic out_full;
  } mro_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UP   = 4'b0010,
    ST_WALK = 4'b0100,
    ST_FIN  = 4'b1000
  } mro_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/mro_ifs.sv -----
`default_nettype none
// input cell channel
interface mro_in_if;
  logic valid;
  logic ready;
  logic cell_req;
  logic last_cell;
  modport source (output valid, cell_req, last_cell, input ready);
  modport sink (input valid, cell_req, last_cell, output ready);
endinterface

// result channel
interface mro_out_if import mro_pkg::*;;
  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] max_area;
  logic              too_many_rows;
  modport source (output valid, max_area, too_many_rows, input ready);
  modport sink (input valid, max_area, too_many_rows, output ready);
endinterface

// row length write channel
interface mro_cfg_if import mro_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ROW_LEN_W-1:0] row_length;
  modport source (output valid, row_length, input ready);
  modport sink (input valid, row_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/maximal_rectangle_of_ones.sv -----
// a cell is accepted, starts, takes W walk steps, W = min(up run, row + 1) - 1 (0 for a zero cell),
// and finishes; a cell past the row limit goes from accept to finish; one left-run read per step
// one cell at a time; a last cell holds in its final cycle while an older result waits
// the result is valid the cycle after the last cell finishes and waits in a register
// rst is synchronous: clears position, best area, flag and output valid, row length 64
// the run memories are not cleared; every entry read is written earlier in the matrix
`default_nettype none
module maximal_rectangle_of_ones import mro_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  mro_in_if.sink    in_ch,
  mro_out_if.source out_ch,
  mro_cfg_if.sink   cfg
);

  mro_cmd_t cmd;
  mro_sts_t sts;

  // row length writes are always taken
  assign cfg.ready = 1'b1;

  mro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mro_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cell_req      (in_ch.cell_req),
    .last_cell     (in_ch.last_cell),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.row_length),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .max_area      (out_ch.max_area),
    .too_many_rows (out_ch.too_many_rows)
  );

endmodule
`default_nettype wire

// ----- rtl/core/mro_ram.sv -----
`default_nettype none
module mro_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/mro_ctrl.sv -----
`default_nettype none
module mro_ctrl import mro_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire mro_sts_t sts,
  output mro_cmd_t      cmd
);

  mro_state_t state, state_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.skip ? ST_FIN : ST_UP;
        end
      end
      ST_UP: begin
        cmd.start  = 1'b1;
        state_next = sts.walk_more ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.walk_more) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!(sts.last && sts.out_full)) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mro_dp.sv -----
`default_nettype none
module mro_dp import mro_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mro_cmd_t             cmd,
  output mro_sts_t                  sts,
  input  wire logic                 cell_req,
  input  wire logic                 last_cell,
  input  wire logic                 cfg_we,
  input  wire logic [ROW_LEN_W-1:0] cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [AREA_W-1:0]         max_area,
  output logic                      too_many_rows
);

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW   = $clog2(MAX_COLS + 1);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int DEP  = MAX_ROWS * MAX_COLS;
  localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;
  localparam int PW   = LW + RW;

  logic [ROW_LEN_W-1:0] row_length;
  logic [RW-1:0]        row;
  logic [CW-1:0]        col;
  logic [LW-1:0]        cur_left;
  logic [AREA_W-1:0]    best;
  logic                 ovf;
  logic                 cell_q;
  logic                 last_q;
  logic [LW-1:0]        mn;
  logic [RW-1:0]        k;
  logic [RW-1:0]        up_q;

  logic [LW-1:0]        eff_len;
  logic                 col_ge;
  logic [RW-1:0]        row_inc;
  logic [RW-1:0]        r0;
  logic [CW-1:0]        c0;
  logic [LW-1:0]        left_new;
  logic [RW-1:0]        up_new;
  logic [RW-1:0]        up_rdata;
  logic [LW-1:0]        left_rdata;
  logic [RW-1:0]        k_next;
  logic [LW-1:0]        mn_new;
  logic [PW-1:0]        prod;
  logic [AREA_W-1:0]    area;
  logic [RW-1:0]        row_rd;
  logic [AW-1:0]        left_waddr;
  logic [AW-1:0]        left_raddr;
  logic [LW-1:0]        col_n;
  logic                 start_more;
  logic                 walk_more;

  // effective row length and row advance for the next cell
  always_comb begin
    if (row_length == '0) begin
      eff_len = LW'(1);
    end else if (32'(row_length) > MAX_COLS) begin
      eff_len = LW'(MAX_COLS);
    end else begin
      eff_len = LW'(row_length);
    end
    col_ge  = 32'(col) >= 32'(eff_len);
    row_inc = (32'(row) < MAX_ROWS) ? row + RW'(1) : row;
    r0      = col_ge ? row_inc : row;
    c0      = col_ge ? '0 : col;
    col_n   = LW'(col) + LW'(1);
  end

  // runs for the current cell
  always_comb begin
    if (!cell_q) begin
      left_new = '0;
    end else if (col == '0) begin
      left_new = LW'(1);
    end else if (32'(cur_left) + 32'd1 > MAX_COLS) begin
      left_new = LW'(MAX_COLS);
    end else begin
      left_new = cur_left + LW'(1);
    end
    if (!cell_q) begin
      up_new = '0;
    end else if (row == '0) begin
      up_new = RW'(1);
    end else if (32'(up_rdata) + 32'd1 > MAX_ROWS) begin
      up_new = RW'(MAX_ROWS);
    end else begin
      up_new = up_rdata + RW'(1);
    end
    start_more = (32'(up_new) >= 32'd2) && (row != '0);
  end

  // one step of the upward walk
  always_comb begin
    k_next = k + RW'(1);
    mn_new = (left_rdata < mn) ? left_rdata : mn;
    prod   = PW'(mn_new) * PW'(k_next);
    area   = (32'(prod) > 32'(AREA_MAX)) ? AREA_MAX : AREA_W'(prod);
    walk_more = (k_next < up_q) && (k_next <= row);
  end

  // left run store addressing
  always_comb begin
    row_rd     = cmd.start ? row - RW'(1) : row - k_next;
    left_waddr = AW'(row) * AW'(MAX_COLS) + AW'(col);
    left_raddr = AW'(row_rd) * AW'(MAX_COLS) + AW'(col);
  end

  always_comb begin
    sts.skip      = 32'(r0) >= MAX_ROWS;
    sts.walk_more = cmd.start ? start_more : walk_more;
    sts.last      = last_q;
    sts.out_full  = out_valid && !out_ready;
  end

  mro_ram #(.WIDTH(RW), .DEPTH(MAX_COLS)) u_up_ram (
    .clk   (clk),
    .we    (cmd.start),
    .waddr (col),
    .wdata (up_new),
    .raddr (c0),
    .rdata (up_rdata)
  );

  mro_ram #(.WIDTH(LW), .DEPTH(DEP)) u_left_ram (
    .clk   (clk),
    .we    (cmd.start),
    .waddr (left_waddr),
    .wdata (left_new),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  // row length register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LEN_RESET;
    end else if (cfg_we) begin
      row_length <= cfg_data;
    end
  end

  // matrix position, runs, best area
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      cur_left <= '0;
      best     <= '0;
      ovf      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        row <= r0;
        col <= c0;
        if (sts.skip) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.start) begin
        cur_left <= left_new;
        if (AREA_W'(left_new) > best) begin
          best <= AREA_W'(left_new);
        end
      end
      if (cmd.walk && (area > best)) begin
        best <= area;
      end
      if (cmd.finish) begin
        if (last_q) begin
          row      <= '0;
          col      <= '0;
          cur_left <= '0;
          best     <= '0;
          ovf      <= 1'b0;
        end else if (col_n >= eff_len) begin
          col <= '0;
          row <= row_inc;
        end else begin
          col <= CW'(col_n);
        end
      end
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cell_q <= cell_req;
      last_q <= last_cell;
    end
    if (cmd.start) begin
      mn   <= left_new;
      k    <= RW'(1);
      up_q <= up_new;
    end
    if (cmd.walk) begin
      mn <= mn_new;
      k  <= k_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && last_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_q) begin
      max_area      <= best;
      too_many_rows <= ovf;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mro_check.sv -----
`default_nettype none
module mro_check import mro_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [AREA_W-1:0] max_area,
  input wire logic              too_many_rows
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(max_area) && $stable(too_many_rows))
    else $error("result changed while stalled");

  // a cell is worked on before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a cell is in work");

  // a result appears only at the end of a cell's work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a finished cell");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind maximal_rectangle_of_ones mro_check u_mro_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .max_area      (out_ch.max_area),
  .too_many_rows (out_ch.too_many_rows)
);
`default_nettype wire
